[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NFGCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NFGCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/nfgcs_pkg.sv]
// ----------------------------------------------------------------------------
// nfgcs_pkg
// Types, codes and constants shared by the nearest free grid cell search.
// ----------------------------------------------------------------------------
package nfgcs_pkg;

  localparam int MAX_RECTS_DEF = 64;
  localparam int GRID_CELLS    = 64;
  localparam int HM_ORIGIN     = 12;
  localparam int COORD_W       = $clog2(GRID_CELLS);
  localparam int DIST_W        = 2 * COORD_W + 1;
  localparam int RECT_W        = 7;
  localparam int WANT_W        = 9;
  localparam int CFG_W         = 8;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_PRESENT = 3'd0,
    REG_HM_WIDTH    = 3'd1,
    REG_HM_HEIGHT   = 3'd2,
    REG_TM_LEFT     = 3'd3,
    REG_TM_TOP      = 3'd4,
    REG_TM_WIDTH    = 3'd5,
    REG_TM_HEIGHT   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [RECT_W-1:0] left;
    logic [RECT_W-1:0] top;
    logic [RECT_W-1:0] width;
    logic [RECT_W-1:0] height;
  } rect_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic               occ;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } probe_t;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } result_t;

endpackage

[rtl/core/nfgcs_if.sv]
// ----------------------------------------------------------------------------
// nfgcs channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface nfgcs_in_if;
  import nfgcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic [RECT_W-1:0]        rect_left;
  logic [RECT_W-1:0]        rect_top;
  logic [RECT_W-1:0]        rect_width;
  logic [RECT_W-1:0]        rect_height;
  logic signed [WANT_W-1:0] want_x;
  logic signed [WANT_W-1:0] want_y;

  modport source (
    output valid, command, rect_left, rect_top, rect_width, rect_height, want_x, want_y,
    input  ready
  );
  modport sink (
    input  valid, command, rect_left, rect_top, rect_width, rect_height, want_x, want_y,
    output ready
  );
endinterface

interface nfgcs_out_if;
  import nfgcs_pkg::*;

  logic         valid;
  logic         ready;
  logic [5:0]   cell_x;
  logic [5:0]   cell_y;
  logic         found_free;

  modport source (output valid, cell_x, cell_y, found_free, input ready);
  modport sink   (input valid, cell_x, cell_y, found_free, output ready);
endinterface

[rtl/core/nearest_free_grid_cell_search.sv]
// ----------------------------------------------------------------------------
// nearest_free_grid_cell_search
// Keeps a table of occupied rectangles and finds the nearest free grid cell.
// ----------------------------------------------------------------------------
// Clear and append words are handled without leaving the idle state. A query
// walks its search window in raster order, sending one candidate cell per
// cycle down a chain of MAX_RECTS rectangle cells that flag any overlap, then
// through a two-stage distance tracker that yields its result word. With no
// map the window is the whole 64 by 64 grid. No new word is taken while a
// query runs, but clears and appends are taken while a finished result
// waits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_free_grid_cell_search #(
  parameter int MAX_RECTS = nfgcs_pkg::MAX_RECTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  nfgcs_in_if.sink                         in_ch,
  nfgcs_out_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [nfgcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [nfgcs_pkg::CFG_W-1:0]      cfg_data
);
  import nfgcs_pkg::*;

  localparam int CNT_W = $clog2(MAX_RECTS + 1);
  localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam logic [COORD_W-1:0] TOP_CELL = COORD_W'(GRID_CELLS - 1);
  localparam logic [COORD_W-1:0] HM_ORG   = COORD_W'(HM_ORIGIN);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_WAIT,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo;
    logic [COORD_W-1:0] hi;
  } span_t;

  state_t               state_r;
  logic                 map_present_r;
  logic [CFG_W-1:0]     hm_w_r;
  logic [CFG_W-1:0]     hm_h_r;
  logic [CFG_W-1:0]     tm_left_r;
  logic [CFG_W-1:0]     tm_top_r;
  logic [CFG_W-1:0]     tm_w_r;
  logic [CFG_W-1:0]     tm_h_r;
  logic [CNT_W-1:0]     count_r;
  logic signed [WANT_W-1:0] want_x_r;
  logic signed [WANT_W-1:0] want_y_r;
  span_t                win_x_r;
  span_t                win_y_r;
  logic [COORD_W-1:0]   sx_r;
  logic [COORD_W-1:0]   sy_r;
  logic [COORD_W-1:0]   x_r;
  logic [COORD_W-1:0]   y_r;
  logic                 out_valid_r;
  logic [COORD_W-1:0]   out_x_r;
  logic [COORD_W-1:0]   out_y_r;
  logic                 out_found_r;
  logic                 accept;
  logic                 do_append;
  logic                 scan_last;
  span_t                span_x;
  span_t                span_y;
  logic [COORD_W-1:0]   start_x;
  logic [COORD_W-1:0]   start_y;
  rect_t                wr_rect;
  result_t              res;
  probe_t               chain [MAX_RECTS+1];

  function automatic span_t axis_span(input logic [CFG_W-1:0] tm_org,
                                      input logic [CFG_W-1:0] tm_size,
                                      input logic [CFG_W-1:0] hm_size);
    logic [CFG_W:0]     e_hm;
    logic [CFG_W:0]     e_tm;
    logic [CFG_W:0]     e_max;
    logic [CFG_W:0]     e_last;
    span_t              s;
    e_hm   = (CFG_W+1)'(HM_ORIGIN) + {1'b0, hm_size};
    e_tm   = {1'b0, tm_org} + {1'b0, tm_size};
    e_max  = (e_hm > e_tm) ? e_hm : e_tm;
    e_last = e_max - (CFG_W+1)'(1);
    s.lo   = ({1'b0, tm_org} < (CFG_W+1)'(HM_ORIGIN)) ? tm_org[COORD_W-1:0] : HM_ORG;
    s.hi   = (e_last > (CFG_W+1)'(TOP_CELL)) ? TOP_CELL : e_last[COORD_W-1:0];
    if (s.hi < s.lo) begin
      s.hi = s.lo;
    end
    return s;
  endfunction

  function automatic logic [COORD_W-1:0] start_cell(input logic signed [WANT_W-1:0] want,
                                                    input span_t s);
    logic [WANT_W-1:0]   inc;
    logic [WANT_W-2:0]   r;
    logic [COORD_W-1:0]  c;
    inc = want + WANT_W'(1);
    r   = inc[WANT_W-1:1];
    if (want < 0 || r < (WANT_W-1)'(s.lo)) begin
      c = s.lo;
    end else if (r > (WANT_W-1)'(s.hi)) begin
      c = s.hi;
    end else begin
      c = r[COORD_W-1:0];
    end
    return c;
  endfunction

  always_comb begin
    if (map_present_r) begin
      span_x = axis_span(tm_left_r, tm_w_r, hm_w_r);
      span_y = axis_span(tm_top_r, tm_h_r, hm_h_r);
    end else begin
      span_x = '{lo: '0, hi: TOP_CELL};
      span_y = '{lo: '0, hi: TOP_CELL};
    end
    start_x = start_cell(want_x_r, span_x);
    start_y = start_cell(want_y_r, span_y);
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign do_append   = accept && (in_ch.command == CMD_APPEND) &&
                       (count_r < CNT_W'(MAX_RECTS));
  assign scan_last   = (x_r == win_x_r.hi) && (y_r == win_y_r.hi);

  assign wr_rect.left   = in_ch.rect_left;
  assign wr_rect.top    = in_ch.rect_top;
  assign wr_rect.width  = in_ch.rect_width;
  assign wr_rect.height = in_ch.rect_height;

  always_comb begin
    chain[0].valid = (state_r == ST_SCAN);
    chain[0].last  = scan_last;
    chain[0].occ   = 1'b0;
    chain[0].x     = x_r;
    chain[0].y     = y_r;
  end

  for (genvar g = 0; g < MAX_RECTS; g++) begin : g_cell
    nfgcs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .we        (do_append && (count_r[IDX_W-1:0] == IDX_W'(g))),
      .wr_rect   (wr_rect),
      .active    (count_r > CNT_W'(g)),
      .probe_in  (chain[g]),
      .probe_out (chain[g+1])
    );
  end

  nfgcs_best u_best (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_SETUP),
    .probe (chain[MAX_RECTS]),
    .sx    (sx_r),
    .sy    (sy_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_present_r <= 1'b0;
      hm_w_r        <= '0;
      hm_h_r        <= '0;
      tm_left_r     <= '0;
      tm_top_r      <= '0;
      tm_w_r        <= '0;
      tm_h_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_MAP_PRESENT: map_present_r <= cfg_data[0];
        REG_HM_WIDTH:    hm_w_r        <= cfg_data;
        REG_HM_HEIGHT:   hm_h_r        <= cfg_data;
        REG_TM_LEFT:     tm_left_r     <= cfg_data;
        REG_TM_TOP:      tm_top_r      <= cfg_data;
        REG_TM_WIDTH:    tm_w_r        <= cfg_data;
        REG_TM_HEIGHT:   tm_h_r        <= cfg_data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_found_r <= 1'b0;
      want_x_r    <= '0;
      want_y_r    <= '0;
      win_x_r     <= '0;
      win_y_r     <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      x_r         <= '0;
      y_r         <= '0;
    end else begin
      if (out_valid_r && out_ch.ready && (state_r != ST_PUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (in_ch.command)
              CMD_CLEAR: count_r <= '0;
              CMD_APPEND: begin
                if (do_append) begin
                  count_r <= count_r + CNT_W'(1);
                end
              end
              CMD_QUERY: begin
                want_x_r <= in_ch.want_x;
                want_y_r <= in_ch.want_y;
                state_r  <= ST_SETUP;
              end
              default: ;
            endcase
          end
        end
        ST_SETUP: begin
          win_x_r <= span_x;
          win_y_r <= span_y;
          sx_r    <= start_x;
          sy_r    <= start_y;
          x_r     <= span_x.lo;
          y_r     <= span_y.lo;
          state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (x_r == win_x_r.hi) begin
            x_r <= win_x_r.lo;
            y_r <= y_r + COORD_W'(1);
          end else begin
            x_r <= x_r + COORD_W'(1);
          end
          if (scan_last) begin
            state_r <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (res.done) begin
            state_r <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= res.x;
            out_y_r     <= res.y;
            out_found_r <= res.found;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_x     = out_x_r;
  assign out_ch.cell_y     = out_y_r;
  assign out_ch.found_free = out_found_r;

  `NFGCS_ASSERT_IMP(a_idle_drained, state_r == ST_IDLE, !chain[MAX_RECTS].valid, "probe left in chain while idle")
  `NFGCS_ASSERT_IMP(a_done_in_wait, res.done, state_r == ST_WAIT, "tracker finished outside wait state")
  `NFGCS_ASSERT_IMP(a_out_from_put, $rose(out_valid_r), $past(state_r == ST_PUT), "result word raised outside put state")
  `NFGCS_ASSERT_NXT(a_clear_empties, accept && in_ch.command == CMD_CLEAR, count_r == '0, "clear did not empty the table")

endmodule

[rtl/core/nfgcs_cell.sv]
// ----------------------------------------------------------------------------
// nfgcs_cell
// One stage of the rectangle chain: holds one rectangle and marks a passing
// probe as occupied when the probed grid cell overlaps it.
// ----------------------------------------------------------------------------
module nfgcs_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  nfgcs_pkg::rect_t wr_rect,
  input  logic             active,
  input  nfgcs_pkg::probe_t probe_in,
  output nfgcs_pkg::probe_t probe_out
);
  import nfgcs_pkg::*;

  localparam int CMP_W = COORD_W + 3;

  rect_t             rect_r;
  probe_t            probe_r;
  logic [CMP_W-1:0]  x2;
  logic [CMP_W-1:0]  y2;
  logic [CMP_W-1:0]  rgt;
  logic [CMP_W-1:0]  bot;
  logic              hit;

  always_comb begin
    x2  = CMP_W'({probe_in.x, 1'b0});
    y2  = CMP_W'({probe_in.y, 1'b0});
    rgt = CMP_W'(rect_r.left) + CMP_W'(rect_r.width);
    bot = CMP_W'(rect_r.top) + CMP_W'(rect_r.height);
    hit = active && (x2 < rgt) && ((x2 + CMP_W'(2)) > CMP_W'(rect_r.left)) &&
          (y2 < bot) && ((y2 + CMP_W'(2)) > CMP_W'(rect_r.top));
  end

  always_ff @(posedge clk) begin
    if (we) begin
      rect_r <= wr_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.valid <= 1'b0;
    end else begin
      probe_r.valid <= probe_in.valid;
    end
    probe_r.last <= probe_in.last;
    probe_r.occ  <= probe_in.occ | hit;
    probe_r.x    <= probe_in.x;
    probe_r.y    <= probe_in.y;
  end

  assign probe_out = probe_r;

endmodule

[rtl/core/nfgcs_best.sv]
// ----------------------------------------------------------------------------
// nfgcs_best
// Closest-free tracker at the end of the chain: squares the offsets of each
// probed cell from the start cell, then keeps the first free cell of least distance.
// ----------------------------------------------------------------------------
module nfgcs_best (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  nfgcs_pkg::probe_t              probe,
  input  logic [nfgcs_pkg::COORD_W-1:0]  sx,
  input  logic [nfgcs_pkg::COORD_W-1:0]  sy,
  output nfgcs_pkg::result_t             res
);
  import nfgcs_pkg::*;

  localparam int SQ_W = 2 * COORD_W;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic [2*COORD_W+1:0]        px;
  logic [2*COORD_W+1:0]        py;
  logic                        a_valid_r;
  logic                        a_last_r;
  logic                        a_free_r;
  logic [COORD_W-1:0]          a_x_r;
  logic [COORD_W-1:0]          a_y_r;
  logic [SQ_W-1:0]             dx2_r;
  logic [SQ_W-1:0]             dy2_r;
  logic [DIST_W-1:0]           cand_dist;
  logic [DIST_W-1:0]           best_r;
  logic                        found_r;
  logic                        done_r;
  logic [COORD_W-1:0]          bx_r;
  logic [COORD_W-1:0]          by_r;

  always_comb begin
    dx        = $signed({1'b0, probe.x}) - $signed({1'b0, sx});
    dy        = $signed({1'b0, probe.y}) - $signed({1'b0, sy});
    px        = dx * dx;
    py        = dy * dy;
    cand_dist = DIST_W'(dx2_r) + DIST_W'(dy2_r);
  end

  always_ff @(posedge clk) begin
    a_last_r <= probe.last;
    a_free_r <= !probe.occ;
    a_x_r    <= probe.x;
    a_y_r    <= probe.y;
    dx2_r    <= px[SQ_W-1:0];
    dy2_r    <= py[SQ_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      found_r   <= 1'b0;
      done_r    <= 1'b0;
      best_r    <= '0;
      bx_r      <= '0;
      by_r      <= '0;
    end else begin
      a_valid_r <= probe.valid;
      done_r    <= a_valid_r && a_last_r;
      if (start) begin
        found_r <= 1'b0;
      end else if (a_valid_r && a_free_r && (!found_r || cand_dist < best_r)) begin
        found_r <= 1'b1;
        best_r  <= cand_dist;
        bx_r    <= a_x_r;
        by_r    <= a_y_r;
      end
    end
  end

  always_comb begin
    res.done  = done_r;
    res.found = found_r;
    res.x     = found_r ? bx_r : sx;
    res.y     = found_r ? by_r : sy;
  end

endmodule
